FILE: sv/kfs_pkg.sv
// Shared constants, types and state codes of the keyframe sampler.
package kfs_pkg;

  localparam int MAX_KEYS = 64;
  localparam int IDX_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int FRAC_W   = 16;
  localparam int DCNT_W   = $clog2(FRAC_W);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_ZERO_SEG = 2'd2;

  // One key: time stamp and four Q16.16 components (x in entry 0).
  typedef struct packed {
    logic [31:0]      stamp;
    logic [3:0][31:0] comp;
  } key_t;

  // Controls that the sequencer hands to every cell.
  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_DIV,
    S_MUL,
    S_EMIT
  } state_e;

endpackage

FILE: sv/kfs_if.sv
// Item channel interfaces of the keyframe sampler.
interface kfs_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [5:0]  key_slot;
  logic [31:0] key_stamp;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;
  logic signed [31:0] comp_w;
  logic [31:0] sample_time;

  modport source (output valid, opcode, key_slot, key_stamp, comp_x, comp_y, comp_z,
                  comp_w, sample_time, input ready);
  modport sink (input valid, opcode, key_slot, key_stamp, comp_x, comp_y, comp_z,
                comp_w, sample_time, output ready);
endinterface

interface kfs_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] blend_x;
  logic signed [31:0] blend_y;
  logic signed [31:0] blend_z;
  logic signed [31:0] blend_w;
  logic [5:0]  segment_found;
  logic [1:0]  status;

  modport source (output valid, blend_x, blend_y, blend_z, blend_w, segment_found, status,
                  input ready);
  modport sink (input valid, blend_x, blend_y, blend_z, blend_w, segment_found, status,
                output ready);
endinterface

FILE: sv/kfs_cell.sv
// One key cell of the rotating key ring.
module kfs_cell (
  input  logic                clk_i,
  input  kfs_pkg::cell_ctrl_t ctrl_i,
  input  kfs_pkg::key_t       wr_key_i,
  input  kfs_pkg::key_t       next_key_i,
  output kfs_pkg::key_t       key_o
);

  kfs_pkg::key_t key_q;

  // Rotate toward the head during a scan, otherwise take a direct write.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      key_q <= next_key_i;
    end else if (ctrl_i.wr) begin
      key_q <= wr_key_i;
    end
  end

  assign key_o = key_q;

endmodule

FILE: sv/keyframe_vec4_sampler.sv
// Top level of the keyframe sampler: key ring, scan, divider and blend sequencer.
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    opcode, key_slot, key_stamp, comp_x..w, sample_time
//  out_o    out  valid/ready    blend_x..w, segment_found, status
//  cfg      in   cfg_we_i       cfg_wdata_i (keys_in_use)
//
// A key write goes straight into its cell. A sample makes one full turn of the key
// ring past the head, then the check, then 16 divider steps and a blend of each of the
// four components in turn (one shared multiplier), then it loads the output register.
// Reset clears the control state only; the key ring holds whatever was written. A
// stalled output holds its item while the next item is already accepted.
module keyframe_vec4_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  kfs_in_if.sink      in_i,
  kfs_out_if.source   out_o
);

  kfs_pkg::state_e state_q, state_d;

  logic [6:0]                 keys_q;
  logic [kfs_pkg::CNT_W-1:0]  n_eff;
  logic [kfs_pkg::CNT_W-1:0]  n_q;
  logic [kfs_pkg::IDX_W-1:0]  cnt_q;
  logic [kfs_pkg::CNT_W-1:0]  cnt_ext;
  logic [31:0]                t_q;
  logic                       found_q;
  logic [kfs_pkg::IDX_W-1:0]  seg_q;
  kfs_pkg::key_t              lo_q, hi_q, last_q, prev_q, cur_key, wr_key;
  logic [31:0]                rem_q, den_q;
  logic [32:0]                rem2;
  logic [kfs_pkg::FRAC_W-1:0] quo_q;
  logic [kfs_pkg::DCNT_W-1:0] dcnt_q;
  logic [1:0]                 mul_q;
  logic [3:0][31:0]           res_q;
  logic [5:0]                 res_seg_q;
  logic [1:0]                 res_st_q;
  logic                       out_valid_q;
  logic [3:0][31:0]           out_comp_q;
  logic [5:0]                 out_seg_q;
  logic [1:0]                 out_st_q;

  logic in_acc, load_out, shift_en;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic [31:0]        a_sel, b_sel;

  kfs_pkg::key_t cell_key [kfs_pkg::MAX_KEYS];

  // Key count clipped to the ring size.
  assign n_eff = (32'(keys_q) > kfs_pkg::MAX_KEYS) ? kfs_pkg::CNT_W'(kfs_pkg::MAX_KEYS)
                                                   : kfs_pkg::CNT_W'(keys_q);

  assign wr_key.stamp   = in_i.key_stamp;
  assign wr_key.comp[0] = in_i.comp_x;
  assign wr_key.comp[1] = in_i.comp_y;
  assign wr_key.comp[2] = in_i.comp_z;
  assign wr_key.comp[3] = in_i.comp_w;

  // Ring of key cells; each cell takes its upper neighbor's key on a shift.
  for (genvar i = 0; i < kfs_pkg::MAX_KEYS; i++) begin : g_cell
    kfs_pkg::cell_ctrl_t ctrl;
    assign ctrl.shift = shift_en;
    assign ctrl.wr    = in_acc && (in_i.opcode == kfs_pkg::OP_WRITE) &&
                        (32'(in_i.key_slot) == 32'(i));
    kfs_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .wr_key_i   (wr_key),
      .next_key_i (cell_key[(i + 1) % kfs_pkg::MAX_KEYS]),
      .key_o      (cell_key[i])
    );
  end

  assign cur_key = cell_key[0];
  assign cnt_ext = kfs_pkg::CNT_W'(cnt_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kfs_pkg::S_IDLE: begin
        if (in_i.valid && in_i.opcode == kfs_pkg::OP_SAMPLE) state_d = kfs_pkg::S_SCAN;
      end
      kfs_pkg::S_SCAN: begin
        if (cnt_q == kfs_pkg::IDX_W'(kfs_pkg::MAX_KEYS - 1)) state_d = kfs_pkg::S_CHECK;
      end
      kfs_pkg::S_CHECK: begin
        if (n_q == '0 || !found_q || hi_q.stamp <= lo_q.stamp) begin
          state_d = kfs_pkg::S_EMIT;
        end else begin
          state_d = kfs_pkg::S_DIV;
        end
      end
      kfs_pkg::S_DIV: begin
        if (dcnt_q == '0) state_d = kfs_pkg::S_MUL;
      end
      kfs_pkg::S_MUL: begin
        if (mul_q == 2'd3) state_d = kfs_pkg::S_EMIT;
      end
      kfs_pkg::S_EMIT: begin
        if (!out_valid_q || out_o.ready) state_d = kfs_pkg::S_IDLE;
      end
      default: state_d = kfs_pkg::S_IDLE;
    endcase
  end

  // Handshake and ring controls.
  always_comb begin
    in_i.ready = 1'b0;
    shift_en   = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      kfs_pkg::S_IDLE: in_i.ready = 1'b1;
      kfs_pkg::S_SCAN: shift_en = 1'b1;
      kfs_pkg::S_EMIT: load_out = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_acc = in_i.valid && in_i.ready;

  // Restoring divider step and blend arithmetic for the selected component.
  assign rem2  = {rem_q, 1'b0};
  assign a_sel = lo_q.comp[mul_q];
  assign b_sel = hi_q.comp[mul_q];
  assign diff  = $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});
  assign prod  = diff * $signed({1'b0, quo_q});

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kfs_pkg::S_IDLE;
      keys_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) keys_q <= cfg_wdata_i;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Scan, check, divide and blend datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      kfs_pkg::S_IDLE: begin
        t_q     <= in_i.sample_time;
        n_q     <= n_eff;
        found_q <= 1'b0;
        cnt_q   <= '0;
      end
      kfs_pkg::S_SCAN: begin
        if (cnt_ext == n_q - 1'b1) last_q <= cur_key;
        if (cnt_q != '0 && cnt_ext < n_q && !found_q && t_q < cur_key.stamp) begin
          found_q <= 1'b1;
          seg_q   <= cnt_q - 1'b1;
          lo_q    <= prev_q;
          hi_q    <= cur_key;
        end
        prev_q <= cur_key;
        cnt_q  <= cnt_q + 1'b1;
      end
      kfs_pkg::S_CHECK: begin
        mul_q  <= '0;
        dcnt_q <= kfs_pkg::DCNT_W'(kfs_pkg::FRAC_W - 1);
        quo_q  <= '0;
        den_q  <= hi_q.stamp - lo_q.stamp;
        rem_q  <= (t_q > lo_q.stamp) ? (t_q - lo_q.stamp) : 32'd0;
        if (n_q == '0) begin
          res_q     <= '0;
          res_seg_q <= '0;
          res_st_q  <= kfs_pkg::ST_EMPTY;
        end else if (!found_q) begin
          res_q     <= last_q.comp;
          res_seg_q <= 6'(n_q - 1'b1);
          res_st_q  <= kfs_pkg::ST_OK;
        end else if (hi_q.stamp <= lo_q.stamp) begin
          res_q     <= lo_q.comp;
          res_seg_q <= 6'(seg_q);
          res_st_q  <= kfs_pkg::ST_ZERO_SEG;
        end else begin
          res_seg_q <= 6'(seg_q);
          res_st_q  <= kfs_pkg::ST_OK;
        end
      end
      kfs_pkg::S_DIV: begin
        if (rem2 >= {1'b0, den_q}) begin
          rem_q <= 32'(rem2 - {1'b0, den_q});
          quo_q <= {quo_q[kfs_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          rem_q <= rem2[31:0];
          quo_q <= {quo_q[kfs_pkg::FRAC_W-2:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 1'b1;
      end
      kfs_pkg::S_MUL: begin
        res_q[mul_q] <= a_sel + 32'(prod[49:16]);
        mul_q        <= mul_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_comp_q <= res_q;
      out_seg_q  <= res_seg_q;
      out_st_q   <= res_st_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.blend_x       = out_comp_q[0];
  assign out_o.blend_y       = out_comp_q[1];
  assign out_o.blend_z       = out_comp_q[2];
  assign out_o.blend_w       = out_comp_q[3];
  assign out_o.segment_found = out_seg_q;
  assign out_o.status        = out_st_q;

endmodule

FILE: sim/tb_keyframe_vec4_sampler.sv
// Self-checking testbench of the keyframe sampler: directed table, full table, random phases.
`timescale 1ns / 100ps

module tb_keyframe_vec4_sampler;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 150;
  localparam int LONG_HOLD  = 600;

  typedef struct {
    logic [31:0] bx, by, bz, bw;
    logic [5:0]  seg;
    logic [1:0]  status;
  } blend_res_t;

  typedef enum int {ROW_WRITE, ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [5:0]  slot;
    logic [31:0] stamp;
    logic [31:0] cx, cy, cz, cw;
    logic [31:0] t;
    bit          typed;
    blend_res_t  res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [6:0] cfg_wdata_i;

  kfs_in_if  in_ch ();
  kfs_out_if out_ch ();

  keyframe_vec4_sampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Shadow copy of the key table and the key count.
  logic [31:0] stamp_shadow [kfs_pkg::MAX_KEYS];
  logic [31:0] comp_shadow  [kfs_pkg::MAX_KEYS][4];
  logic [6:0]  keys_shadow;

  blend_res_t expected_blends [$];
  int  fail_cnt;
  int  rcv_cnt;
  int  idle_cycles;
  bit  handshake_seen;

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Floor blend of one component between two keys.
  function automatic logic [31:0] blend_comp(logic [31:0] a, logic [31:0] b, logic [16:0] f);
    longint sa, sb, prod;
    sa   = longint'($signed(a));
    sb   = longint'($signed(b));
    prod = (sb - sa) * longint'(f);
    return 32'(sa + (prod >>> 16));
  endfunction

  function automatic blend_res_t key_result(int k, int seg, logic [1:0] st);
    blend_res_t r;
    r.bx = comp_shadow[k][0];
    r.by = comp_shadow[k][1];
    r.bz = comp_shadow[k][2];
    r.bw = comp_shadow[k][3];
    r.seg = 6'(seg);
    r.status = st;
    return r;
  endfunction

  // Expected result of a sample at time t against the shadow table.
  function automatic blend_res_t predict_blend(logic [31:0] t);
    blend_res_t r;
    int n, seg;
    bit found;
    logic [31:0] lo, hi;
    logic [47:0] quot;
    logic [16:0] f;
    n = (keys_shadow > kfs_pkg::MAX_KEYS) ? kfs_pkg::MAX_KEYS : int'(keys_shadow);
    found = 0;
    seg = 0;
    if (n == 0) begin
      r = '{default: '0};
      r.status = kfs_pkg::ST_EMPTY;
      return r;
    end
    if (n == 1) return key_result(0, 0, kfs_pkg::ST_OK);
    for (int i = 0; i + 1 < n; i++) begin
      if (!found && t < stamp_shadow[i + 1]) begin
        seg = i;
        found = 1;
      end
    end
    if (!found) return key_result(n - 1, n - 1, kfs_pkg::ST_OK);
    lo = stamp_shadow[seg];
    hi = stamp_shadow[seg + 1];
    if (hi <= lo) return key_result(seg, seg, kfs_pkg::ST_ZERO_SEG);
    if (t <= lo) begin
      f = '0;
    end else begin
      quot = {t - lo, 16'h0} / {16'h0, hi - lo};
      f = (quot > 48'h10000) ? 17'h10000 : quot[16:0];
    end
    r.bx = blend_comp(comp_shadow[seg][0], comp_shadow[seg + 1][0], f);
    r.by = blend_comp(comp_shadow[seg][1], comp_shadow[seg + 1][1], f);
    r.bz = blend_comp(comp_shadow[seg][2], comp_shadow[seg + 1][2], f);
    r.bw = blend_comp(comp_shadow[seg][3], comp_shadow[seg + 1][3], f);
    r.seg = 6'(seg);
    r.status = kfs_pkg::ST_OK;
    return r;
  endfunction

  // Offer one item and wait for it to be accepted, then update the shadow state.
  task automatic send_item(stim_row_t row);
    int gap;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= (row.kind == ROW_SAMPLE) ? kfs_pkg::OP_SAMPLE : kfs_pkg::OP_WRITE;
    in_ch.key_slot    <= row.slot;
    in_ch.key_stamp   <= row.stamp;
    in_ch.comp_x      <= row.cx;
    in_ch.comp_y      <= row.cy;
    in_ch.comp_z      <= row.cz;
    in_ch.comp_w      <= row.cw;
    in_ch.sample_time <= row.t;
    do @(posedge clk_i); while (!in_ch.ready);
    if (row.kind == ROW_WRITE) begin
      stamp_shadow[row.slot] = row.stamp;
      comp_shadow[row.slot]  = '{row.cx, row.cy, row.cz, row.cw};
    end else begin
      expected_blends.push_back(row.typed ? row.res : predict_blend(row.t));
    end
  endtask

  // Let the block drain, then write the key count.
  task automatic write_key_count(logic [6:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_blends.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    keys_shadow = value;
  endtask

  task automatic run_row(stim_row_t row);
    if (row.kind == ROW_CFG) write_key_count(row.t[6:0]);
    else send_item(row);
  endtask

  function automatic stim_row_t mk_row(row_kind_e k, logic [5:0] slot, logic [31:0] stamp,
                                       logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                       logic [31:0] cw, logic [31:0] t);
    stim_row_t r;
    r.kind = k; r.slot = slot; r.stamp = stamp;
    r.cx = cx; r.cy = cy; r.cz = cz; r.cw = cw; r.t = t;
    r.typed = 0;
    r.res = '{default: '0};
    return r;
  endfunction

  function automatic stim_row_t mk_typed(logic [31:0] t, logic [31:0] bx, logic [31:0] by,
                                         logic [31:0] bz, logic [31:0] bw, logic [5:0] seg,
                                         logic [1:0] st);
    stim_row_t r;
    r = mk_row(ROW_SAMPLE, 6'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
               t);
    r.typed = 1;
    r.res = '{bx, by, bz, bw, seg, st};
    return r;
  endfunction

  function automatic stim_row_t mk_write(logic [5:0] slot, logic [31:0] stamp);
    return mk_row(ROW_WRITE, slot, stamp, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic stim_row_t mk_sample(logic [31:0] t);
    return mk_row(ROW_SAMPLE, 6'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                  t);
  endfunction

  function automatic stim_row_t mk_cfg(logic [6:0] v);
    return mk_row(ROW_CFG, 6'd0, 0, 0, 0, 0, 0, {25'h0, v});
  endfunction

  // Result side: random stalls, one long hold, field checks.
  initial begin
    int gap;
    blend_res_t e;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (rcv_cnt == 12) gap = LONG_HOLD;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      rcv_cnt++;
      if (expected_blends.size() == 0) begin
        $error("unexpected result item: seg=%0d status=%0d",
               out_ch.segment_found, out_ch.status);
        fail_cnt++;
      end else begin
        e = expected_blends.pop_front();
        if (out_ch.blend_x !== e.bx) begin
          $error("blend_x: expected %h, got %h", e.bx, out_ch.blend_x); fail_cnt++;
        end
        if (out_ch.blend_y !== e.by) begin
          $error("blend_y: expected %h, got %h", e.by, out_ch.blend_y); fail_cnt++;
        end
        if (out_ch.blend_z !== e.bz) begin
          $error("blend_z: expected %h, got %h", e.bz, out_ch.blend_z); fail_cnt++;
        end
        if (out_ch.blend_w !== e.bw) begin
          $error("blend_w: expected %h, got %h", e.bw, out_ch.blend_w); fail_cnt++;
        end
        if (out_ch.segment_found !== e.seg) begin
          $error("segment_found: expected %0d, got %0d", e.seg, out_ch.segment_found);
          fail_cnt++;
        end
        if (out_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_ch.status); fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item on either channel.
  always @(posedge clk_i) begin
    handshake_seen = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);
    if (handshake_seen || !rst_ni) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** keyframe_vec4_sampler: FAILED **");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    stim_row_t dir_rows [$];
    logic [31:0] base, stamp_acc;
    int n, items, pick;
    logic [6:0] cfg_v;

    fail_cnt = 0;
    rcv_cnt = 0;
    idle_cycles = 0;
    keys_shadow = '0;
    foreach (stamp_shadow[i]) stamp_shadow[i] = '0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= kfs_pkg::OP_WRITE;
    in_ch.key_slot <= '0;
    in_ch.key_stamp <= '0;
    in_ch.comp_x <= '0;
    in_ch.comp_y <= '0;
    in_ch.comp_z <= '0;
    in_ch.comp_w <= '0;
    in_ch.sample_time <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, single key, extremes, zero-length segment, past the end.
    dir_rows.push_back(mk_typed(32'h0, 0, 0, 0, 0, 6'd0, kfs_pkg::ST_EMPTY));
    dir_rows.push_back(mk_typed(32'hFFFF_FFFF, 0, 0, 0, 0, 6'd0, kfs_pkg::ST_EMPTY));
    dir_rows.push_back(mk_row(ROW_WRITE, 6'd0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'h0, 32'hFFFF_FFFF, 32'h0));
    dir_rows.push_back(mk_row(ROW_WRITE, 6'd1, 32'h0064_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h1, 32'h0, 32'h0));
    dir_rows.push_back(mk_row(ROW_WRITE, 6'd2, 32'h0064_0000, 32'h1234_5678, 32'hFFFF_0000,
                              32'h0001_0000, 32'h8000_0001, 32'h0));
    dir_rows.push_back(mk_row(ROW_WRITE, 6'd3, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h0,
                              32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    dir_rows.push_back(mk_cfg(7'd1));
    dir_rows.push_back(mk_typed(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                32'hFFFF_FFFF, 6'd0, kfs_pkg::ST_OK));
    dir_rows.push_back(mk_cfg(7'd4));
    dir_rows.push_back(mk_sample(32'h0));
    dir_rows.push_back(mk_sample(32'h0032_0000));
    dir_rows.push_back(mk_sample(32'h0063_FFFF));
    dir_rows.push_back(mk_sample(32'h0064_0000));
    dir_rows.push_back(mk_sample(32'hFFFF_FFFE));
    dir_rows.push_back(mk_typed(32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h0, 32'h7FFF_FFFF,
                                32'h8000_0000, 6'd3, kfs_pkg::ST_OK));
    // Descending first segment, sampled before its upper time.
    dir_rows.push_back(mk_write(6'd0, 32'h00C8_0000));
    dir_rows.push_back(mk_sample(32'h0000_0000));
    dir_rows.push_back(mk_sample(32'h0063_0000));
    dir_rows.push_back(mk_write(6'd63, 32'hFFFF_FFFF));
    foreach (dir_rows[i]) run_row(dir_rows[i]);

    // Fill the whole table, then run the largest key count and a saturated one.
    stamp_acc = $urandom_range(0, 1000);
    for (int s = 0; s < kfs_pkg::MAX_KEYS; s++) begin
      send_item(mk_write(6'(s), stamp_acc));
      stamp_acc += $urandom_range(1, 1 << 24);
    end
    items = dir_rows.size() + kfs_pkg::MAX_KEYS;
    for (int p = 0; p < 2; p++) begin
      write_key_count(p == 0 ? 7'd64 : 7'd127);
      for (int k = 0; k < 12; k++) begin
        pick = $urandom_range(0, kfs_pkg::MAX_KEYS - 1);
        send_item(mk_sample(stamp_shadow[pick] + $urandom_range(0, 1 << 24)));
        items++;
      end
    end

    // Random phases: mostly ascending keys with random content, then samples and some key rewrites.
    while (items < 700) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) n = 0;
      else if (pick == 1) n = 1;
      else if (pick == 2) n = $urandom_range(9, 64);
      else n = $urandom_range(2, 8);
      base = (pick == 3) ? $urandom : $urandom_range(0, 32'h7FFF_FFFF);
      stamp_acc = base;
      for (int s = 0; s < n; s++) begin
        send_item(mk_write(6'(s), stamp_acc));
        items++;
        if ($urandom_range(0, 15) == 0) stamp_acc = stamp_acc;
        else if ($urandom_range(0, 15) == 0 && s == 0) stamp_acc = stamp_acc - 1;
        else stamp_acc = stamp_acc + $urandom_range(1, 1 << 24);
      end
      cfg_v = (n == 64 && $urandom_range(0, 1)) ? 7'($urandom_range(65, 127)) : 7'(n);
      write_key_count(cfg_v);
      for (int k = 0; k < 20; k++) begin
        pick = $urandom_range(0, 9);
        if (n == 0 || pick == 0) begin
          send_item(mk_sample($urandom));
        end else if (pick == 1) begin
          send_item(mk_sample(stamp_shadow[$urandom_range(0, n - 1)]));
        end else if (pick == 2) begin
          // Noise: rewrite a key already in use with random content.
          send_item(mk_write(6'($urandom_range(0, n - 1)), $urandom));
        end else begin
          send_item(mk_sample(stamp_shadow[$urandom_range(0, n - 1)] +
                              $urandom_range(0, 1 << 24) - (1 << 20)));
        end
        items++;
      end
    end

    // Drain and finish.
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_blends.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** keyframe_vec4_sampler: PASSED **");
    end else begin
      $display("** keyframe_vec4_sampler: FAILED **");
    end
    $finish;
  end

endmodule
